// ----- src/assert_macros.svh -----
// Assertion macros shared by the window peak detector RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on clk, disabled while rst_n is low
`define WPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain invariant on clk, disabled while rst_n is low
`define WPD_INVARIANT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ----- src/wpd_pkg.sv -----
// Package for the window peak detector: constants, register indexes,
// controller/datapath structs and small helper functions. No dependencies.
package wpd_pkg;

    localparam int MAX_HALF_WIDTH = 32;
    localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 8;
    localparam int PTR_W          = $clog2(WIN_DEPTH);
    localparam int CNT_W          = 16;
    localparam int POS_W          = CNT_W + 1;

    // Configuration register indexes
    localparam logic [2:0] CFG_PEAK_MODE  = 3'd0;
    localparam logic [2:0] CFG_THR_ENABLE = 3'd1;
    localparam logic [2:0] CFG_AMP_THR    = 3'd2;
    localparam logic [2:0] CFG_CHG_THR    = 3'd3;
    localparam logic [2:0] CFG_EXCL_HW    = 3'd4;

    // Peak mode codes
    localparam logic [1:0] MODE_THREE = 2'd0;
    localparam logic [1:0] MODE_FIVE  = 2'd1;
    localparam logic [1:0] MODE_SEVEN = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic win_clr;
        logic win_step;
        logic cand;
        logic chg;
        logic j_init;
        logic scan_rd;
        logic scan1_ev;
        logic scan2_ev;
        logic settle_wr;
        logic emit_rd;
        logic emit_ld;
        logic finish;
    } wpd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic win_done;
        logic cls_more;
        logic scan_on;
        logic scan_more;
        logic emit_more;
        logic out_free;
    } wpd_sts_t;

    // Circular pointer plus signed offset, wrapped into the window depth
    function automatic logic [PTR_W-1:0] wpd_wrap(input logic [PTR_W-1:0] ptr,
                                                  input logic signed [7:0] off);
        logic signed [8:0] s;
        s = $signed({2'b00, ptr}) + $signed({off[7], off});
        if (s < 0)
            s = s + $signed(9'(WIN_DEPTH));
        else if (s >= $signed(9'(WIN_DEPTH)))
            s = s - $signed(9'(WIN_DEPTH));
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] wpd_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(WIN_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Fractional drop test as multiply-compare: (y - d) * 4096 vs C * y
    function automatic logic wpd_drop(input logic signed [15:0] y,
                                      input logic signed [15:0] d,
                                      input logic signed [32:0] prod);
        logic signed [16:0] diff;
        logic signed [32:0] lhs;
        diff = $signed({y[15], y}) - $signed({d[15], d});
        lhs  = $signed({{4{diff[16]}}, diff, 12'b0});
        return (y > 0) ? (lhs > prod) : (lhs < prod);
    endfunction

endpackage

// ----- src/window_peak_detector.sv -----
// Window peak detector: 3/5/7-point local maximum, amplitude and change tests, exclusion zone.
// Per sample: an accept step; per classified sample a window read, candidate and change tests,
// an exclusion scan in up to two passes of up to h entries and a flag write; per final flag an
// emit that waits on output stalls; then a closing step. Flags appear once final (about
// h + reach samples behind). One sample in flight; the scan loop sets the pace.
// Reset is asynchronous active low: config registers go to zero and counters restart a sequence.
module window_peak_detector
    import wpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        position,
    output logic               is_peak,
    output logic               last_flag
);

    wpd_cmd_t cmd;
    wpd_sts_t sts;

    wpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wpd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .position    (position),
        .is_peak     (is_peak),
        .last_flag   (last_flag),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ----- src/wpd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 72
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/wpd_ctrl.sv -----
// Controller state machine of the window peak detector.
// Depends on wpd_pkg for the command and status structs.
module wpd_ctrl
    import wpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  wpd_sts_t sts,
    output wpd_cmd_t cmd
);

    typedef enum logic [3:0] {
        IDLE, CLS_CHK, WIN, CAND, CHG, S1_CHK, S1_RD, S1_EV,
        S2_CHK, S2_RD, S2_EV, SET_WR, EMIT_CHK, EMIT_RD, EMIT_LD, FIN
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = CLS_CHK;
                end
            end
            CLS_CHK:
            begin
                if (sts.cls_more)
                begin
                    cmd.win_clr = 1'b1;
                    state_next  = WIN;
                end
                else
                begin
                    state_next = EMIT_CHK;
                end
            end
            WIN:
            begin
                cmd.win_step = 1'b1;
                if (sts.win_done)
                    state_next = CAND;
            end
            CAND:
            begin
                cmd.cand   = 1'b1;
                state_next = CHG;
            end
            CHG:
            begin
                cmd.chg    = 1'b1;
                cmd.j_init = 1'b1;
                state_next = S1_CHK;
            end
            S1_CHK:
            begin
                if (!sts.scan_on)
                    state_next = SET_WR;
                else if (sts.scan_more)
                    state_next = S1_RD;
                else
                begin
                    cmd.j_init = 1'b1;
                    state_next = S2_CHK;
                end
            end
            S1_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S1_EV;
            end
            S1_EV:
            begin
                cmd.scan1_ev = 1'b1;
                state_next   = S1_CHK;
            end
            S2_CHK:
            begin
                state_next = sts.scan_more ? S2_RD : SET_WR;
            end
            S2_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S2_EV;
            end
            S2_EV:
            begin
                cmd.scan2_ev = 1'b1;
                state_next   = S2_CHK;
            end
            SET_WR:
            begin
                cmd.settle_wr = 1'b1;
                state_next    = CLS_CHK;
            end
            EMIT_CHK:
            begin
                state_next = sts.emit_more ? EMIT_RD : FIN;
            end
            EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = EMIT_LD;
            end
            EMIT_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    state_next  = EMIT_CHK;
                end
            end
            FIN:
            begin
                cmd.finish = 1'b1;
                state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- src/wpd_dp.sv -----
// Datapath of the window peak detector: config registers, counters,
// sample and flag stores, candidate test, exclusion scan, output register.
// Depends on wpd_pkg, wpd_ram and assert_macros.svh.
`include "assert_macros.svh"

module wpd_dp
    import wpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic signed [15:0] sample,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        position,
    output logic               is_peak,
    output logic               last_flag,
    input  wpd_cmd_t           cmd,
    output wpd_sts_t           sts
);

    // Configuration
    logic [1:0]         mode_reg;
    logic               thr_en_reg;
    logic signed [15:0] amp_reg;
    logic [15:0]        chg_reg;
    logic [5:0]         excl_reg;

    // Sequence counters and circular pointers
    logic [CNT_W-1:0] n_reg;
    logic [POS_W-1:0] cls_reg, ne_reg, j_reg;
    logic [PTR_W-1:0] n_ptr_reg, cls_ptr_reg, ne_ptr_reg, j_ptr_reg;
    logic             last_reg;
    logic [2:0]       o_reg;
    logic             f_reg;

    // Working values
    logic signed [15:0] win_reg [7];
    logic               c0_reg;
    logic signed [32:0] prod_reg;

    logic        out_valid_reg, is_peak_reg, last_flag_reg;
    logic [15:0] position_reg;

    logic [5:0]         h;
    logic [1:0]         reach;
    logic signed [15:0] y;
    logic signed [7:0]  win_off;
    logic [PTR_W-1:0]   win_addr;

    logic               samp_re, flag_re, flag_we, flag_wdata;
    logic [PTR_W-1:0]   samp_raddr, flag_raddr, flag_waddr;
    logic [15:0]        samp_rdata;
    logic               flag_rdata;
    logic signed [15:0] samp_rd;

    logic c3, c5, c7, cand_c, in_range;
    logic signed [15:0] d_hi, d_lo;
    logic f_chg;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign is_peak   = is_peak_reg;
    assign last_flag = last_flag_reg;

    // Exclusion half-width saturates; reach follows the mode
    assign h     = (excl_reg > 6'(MAX_HALF_WIDTH)) ? 6'(MAX_HALF_WIDTH) : excl_reg;
    assign reach = (mode_reg == MODE_FIVE) ? 2'd2 : ((mode_reg == MODE_SEVEN) ? 2'd3 : 2'd1);
    assign y     = win_reg[3];
    assign samp_rd = $signed(samp_rdata);

    // Status
    always_comb
    begin
        sts.win_done  = (o_reg == 3'd7);
        sts.cls_more  = ({1'b0, cls_reg} <= {2'b00, n_reg}) &&
                        (last_reg || ({1'b0, cls_reg} + 18'(reach) <= {2'b00, n_reg}));
        sts.scan_on   = f_reg && (h != '0);
        sts.scan_more = (j_reg < cls_reg);
        sts.emit_more = (ne_reg < cls_reg) &&
                        (last_reg || ({1'b0, ne_reg} + 18'(h) < {1'b0, cls_reg}));
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Store addressing
    assign win_off    = $signed({5'b0, o_reg}) - 8'sd3;
    assign win_addr   = wpd_wrap(cls_ptr_reg, win_off);
    assign samp_re    = (cmd.win_step && (o_reg != 3'd7)) || cmd.scan_rd;
    assign samp_raddr = cmd.win_step ? win_addr : j_ptr_reg;
    assign flag_re    = cmd.scan_rd || cmd.emit_rd;
    assign flag_raddr = cmd.emit_rd ? ne_ptr_reg : j_ptr_reg;
    assign flag_we    = cmd.settle_wr || (cmd.scan2_ev && flag_rdata && (samp_rd <= y));
    assign flag_waddr = cmd.settle_wr ? cls_ptr_reg : j_ptr_reg;
    assign flag_wdata = cmd.settle_wr ? f_reg : 1'b0;

    wpd_ram #(.WIDTH(16), .DEPTH(WIN_DEPTH)) u_samp_ram (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (n_ptr_reg),
        .wdata (sample),
        .re    (samp_re),
        .raddr (samp_raddr),
        .rdata (samp_rdata)
    );

    wpd_ram #(.WIDTH(1), .DEPTH(WIN_DEPTH)) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (flag_re),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    // Window rules on the seven captured samples
    always_comb
    begin
        c3 = (y > win_reg[2] && y > win_reg[4]) ||
             (y == win_reg[2] && y > win_reg[4]) ||
             (y > win_reg[2] && y == win_reg[4]);
        c5 = c3 && (win_reg[1] < win_reg[2]) && (win_reg[5] < win_reg[4]);
        c7 = (win_reg[0] < win_reg[1]) && (win_reg[1] < win_reg[2]) &&
             (win_reg[2] < y) && (win_reg[4] < y) &&
             (win_reg[5] < win_reg[4]) && (win_reg[6] < win_reg[5]);
        case (mode_reg)
            MODE_FIVE:  cand_c = c5;
            MODE_SEVEN: cand_c = c7;
            default:    cand_c = c3;
        endcase
        if (thr_en_reg && (y < amp_reg))
            cand_c = 1'b0;
        in_range = (cls_reg >= POS_W'(reach)) &&
                   ({1'b0, cls_reg} + 18'(reach) <= {2'b00, n_reg});
    end

    // Fractional change test against both reach neighbors
    always_comb
    begin
        d_hi  = win_reg[3'd3 + {1'b0, reach}];
        d_lo  = win_reg[3'd3 - {1'b0, reach}];
        f_chg = (chg_reg == '0) || (y == 16'sd0) ||
                wpd_drop(y, d_hi, prod_reg) || wpd_drop(y, d_lo, prod_reg);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_THREE;
            thr_en_reg <= 1'b0;
            amp_reg    <= '0;
            chg_reg    <= '0;
            excl_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PEAK_MODE:  mode_reg   <= cfg_data[1:0];
                CFG_THR_ENABLE: thr_en_reg <= cfg_data[0];
                CFG_AMP_THR:    amp_reg    <= $signed(cfg_data);
                CFG_CHG_THR:    chg_reg    <= cfg_data;
                CFG_EXCL_HW:    excl_reg   <= cfg_data[5:0];
                default:        ;
            endcase
        end
    end

    // Counters, pointers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            cls_reg       <= '0;
            ne_reg        <= '0;
            j_reg         <= '0;
            n_ptr_reg     <= '0;
            cls_ptr_reg   <= '0;
            ne_ptr_reg    <= '0;
            j_ptr_reg     <= '0;
            last_reg      <= 1'b0;
            o_reg         <= '0;
            f_reg         <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
                last_reg <= last_sample || (n_reg == '1);
            if (cmd.win_clr)
                o_reg <= '0;
            else if (cmd.win_step)
                o_reg <= o_reg + 3'd1;
            if (cmd.chg)
                f_reg <= c0_reg && f_chg;
            else if (cmd.scan1_ev && flag_rdata && (y <= samp_rd))
                f_reg <= 1'b0;
            // start of the exclusion scan: max(k - h, next emit position)
            if (cmd.j_init)
            begin
                if ({1'b0, cls_reg} >= {1'b0, ne_reg} + 18'(h))
                begin
                    j_reg     <= cls_reg - POS_W'(h);
                    j_ptr_reg <= wpd_wrap(cls_ptr_reg, -$signed({2'b00, h}));
                end
                else
                begin
                    j_reg     <= ne_reg;
                    j_ptr_reg <= ne_ptr_reg;
                end
            end
            else if (cmd.scan1_ev || cmd.scan2_ev)
            begin
                j_reg     <= j_reg + 1'b1;
                j_ptr_reg <= wpd_inc(j_ptr_reg);
            end
            if (cmd.settle_wr)
            begin
                cls_reg     <= cls_reg + 1'b1;
                cls_ptr_reg <= wpd_inc(cls_ptr_reg);
            end
            if (cmd.emit_ld)
            begin
                out_valid_reg <= 1'b1;
                ne_reg        <= ne_reg + 1'b1;
                ne_ptr_reg    <= wpd_inc(ne_ptr_reg);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                if (last_reg)
                begin
                    n_reg       <= '0;
                    cls_reg     <= '0;
                    ne_reg      <= '0;
                    n_ptr_reg   <= '0;
                    cls_ptr_reg <= '0;
                    ne_ptr_reg  <= '0;
                end
                else
                begin
                    n_reg     <= n_reg + 1'b1;
                    n_ptr_reg <= wpd_inc(n_ptr_reg);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.win_step && (o_reg != 3'd0))
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[6] <= samp_rd;
        end
        if (cmd.cand)
        begin
            c0_reg   <= cand_c && in_range;
            prod_reg <= $signed({1'b0, chg_reg}) * y;
        end
        if (cmd.emit_ld)
        begin
            position_reg  <= ne_reg[15:0];
            is_peak_reg   <= flag_rdata;
            last_flag_reg <= last_reg && (ne_reg == {1'b0, n_reg});
        end
    end

    `WPD_INVARIANT(a_emit_behind_cls, ne_reg <= cls_reg, "emit position passed classify position")
    `WPD_INVARIANT(a_cls_bound, {1'b0, cls_reg} <= {2'b00, n_reg} + 18'd1, "classify ran ahead")
    `WPD_ASSERT(a_ptr_range, (n_ptr_reg < PTR_W'(WIN_DEPTH)) |-> (cls_ptr_reg < PTR_W'(WIN_DEPTH) && ne_ptr_reg < PTR_W'(WIN_DEPTH) && j_ptr_reg < PTR_W'(WIN_DEPTH)), "pointer outside store")

endmodule

// ----- test/window_peak_detector_test.sv -----
// Self-checking testbench for window_peak_detector: a queue-fed driver, a receiver with random
// stalls, and a monitor that predicts every peak flag. Depends on wpd_pkg and the RTL.
module window_peak_detector_test;
    import wpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_ALIAS = 2'd3;   // unused code, behaves as three-point
    localparam int DEPTH      = WIN_DEPTH;
    localparam int DRAIN_WAIT = 1500;
    localparam int WATCHDOG   = 20000;
    localparam int LONG_HOLD  = 2000;

    typedef struct {
        logic signed [15:0] value;
        logic               last;
    } sample_t;

    typedef struct {
        logic [15:0] pos;
        logic        peak;
        logic        last;
    } flag_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0, in_ready;
    logic signed [15:0] sample = '0;
    logic last_sample = 1'b0;
    logic out_valid, out_ready = 1'b0;
    logic [15:0] position;
    logic is_peak, last_flag;

    window_peak_detector u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus and expectation stores
    sample_t sample_q[$];
    flag_t   flag_fifo[$];
    int tx_idle = 0, rx_idle = 0;
    bit tx_pause = 1'b0;
    int hold_req = 0, hold_ack = 0, hold_left = 0;
    int errors = 0, n_samples = 0, n_flags = 0, n_peaks = 0, n_cfg = 0;
    int idle_cycles = 0;

    // Predictor state and register copies
    logic [1:0]         m_mode;
    logic               m_thr_en;
    logic signed [15:0] m_amp;
    logic [15:0]        m_chg;
    logic [5:0]         m_hw;
    int                 win[DEPTH];
    bit                 pbits[DEPTH];
    int unsigned        seq_cnt, emit_pos, cls_pos;

    function automatic int at(int unsigned k);
        return win[k % DEPTH];
    endfunction

    // Fractional drop against one neighbour, as exact multiply-compare
    function automatic bit drops(int unsigned i, int unsigned b);
        longint y, lhs, rhs;
        y = at(i);
        lhs = (y - at(b)) * 4096;
        rhs = longint'(m_chg) * y;
        if (y == 0)
            return 1'b1;
        return (y > 0) ? (lhs > rhs) : (lhs < rhs);
    endfunction

    function automatic bit candidate(int unsigned i, int unsigned reach);
        int y, y0, y2;
        bit c;
        y = at(i);
        y0 = at(i - 1);
        y2 = at(i + 1);
        if (m_mode == MODE_SEVEN)
            c = at(i - 3) < at(i - 2) && at(i - 2) < y0 && y0 < y && y2 < y &&
                at(i + 2) < y2 && at(i + 3) < at(i + 2);
        else
        begin
            c = (y > y0 && y > y2) || (y == y0 && y > y2) || (y > y0 && y == y2);
            if (m_mode == MODE_FIVE)
                c = c && at(i - 2) < y0 && at(i + 2) < y2;
        end
        if (c && m_thr_en && y < m_amp)
            c = 1'b0;
        if (c && m_chg != 0)
            c = drops(i, i + reach) || drops(i, i - reach);
        return c;
    endfunction

    // Exclusion zone: new peak must beat earlier pending peaks, then clears lower or equal ones
    function automatic void settle(int unsigned i, bit f, int unsigned h);
        int unsigned lo;
        int y;
        y = at(i);
        if (h != 0 && f)
        begin
            lo = (i >= h) ? i - h : 0;
            if (lo < emit_pos)
                lo = emit_pos;
            for (int unsigned j = lo; j < i; j++)
                if (pbits[j % DEPTH] && y <= at(j))
                    f = 1'b0;
            if (f)
                for (int unsigned j = lo; j < i; j++)
                    if (pbits[j % DEPTH] && at(j) <= y)
                        pbits[j % DEPTH] = 1'b0;
        end
        pbits[i % DEPTH] = f;
    endfunction

    function automatic void predict_flags(logic signed [15:0] s, logic l);
        int unsigned n, reach, h, k;
        bit last, f;
        flag_t e;
        n = seq_cnt;
        reach = (m_mode == MODE_FIVE) ? 2 : ((m_mode == MODE_SEVEN) ? 3 : 1);
        h = (m_hw > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : m_hw;
        last = l || (n + 1 >= 65536);
        win[n % DEPTH] = s;
        while (cls_pos <= n)
        begin
            k = cls_pos;
            if (!last && k + reach > n)
                break;
            f = (k >= reach && k + reach <= n) ? candidate(k, reach) : 1'b0;
            settle(k, f, h);
            cls_pos++;
        end
        while (emit_pos < cls_pos && (last || emit_pos + h < cls_pos))
        begin
            e.pos = emit_pos[15:0];
            e.peak = pbits[emit_pos % DEPTH];
            e.last = last && emit_pos == n;
            flag_fifo.push_back(e);
            emit_pos++;
        end
        if (last)
        begin
            seq_cnt = 0;
            cls_pos = 0;
            emit_pos = 0;
        end
        else
            seq_cnt = n + 1;
    endfunction

    // Driver: next sample goes out once the current one is taken
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (sample_q.size() != 0 && !tx_pause && $urandom_range(99) >= tx_idle)
            begin
                in_valid <= 1'b1;
                sample <= sample_q[0].value;
                last_sample <= sample_q[0].last;
                void'(sample_q.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Monitor: register writes, accepted samples and accepted flags
    always @(posedge clk)
    begin
        flag_t e;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                n_cfg++;
                case (cfg_index)
                    CFG_PEAK_MODE:  m_mode = cfg_data[1:0];
                    CFG_THR_ENABLE: m_thr_en = cfg_data[0];
                    CFG_AMP_THR:    m_amp = cfg_data;
                    CFG_CHG_THR:    m_chg = cfg_data;
                    CFG_EXCL_HW:    m_hw = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                n_samples++;
                predict_flags(sample, last_sample);
            end
            if (out_valid && out_ready)
            begin
                n_flags++;
                n_peaks += is_peak;
                if (flag_fifo.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected flag pos=%0d peak=%0b last=%0b",
                             $realtime, position, is_peak, last_flag);
                end
                else
                begin
                    e = flag_fifo.pop_front();
                    if (position !== e.pos || is_peak !== e.peak || last_flag !== e.last)
                    begin
                        errors++;
                        $display("%0t: flag mismatch exp pos=%0d peak=%0b last=%0b got pos=%0d peak=%0b last=%0b",
                                 $realtime, e.pos, e.peak, e.last, position, is_peak, last_flag);
                    end
                end
            end
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else if (++idle_cycles >= WATCHDOG)
            begin
                $display("%0t: watchdog expired, %0d flags outstanding", $realtime, flag_fifo.size());
                $display("window_peak_detector verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [1:0] mode, logic te, logic [15:0] amp, logic [15:0] chg,
                             logic [5:0] hw);
        write_reg(CFG_PEAK_MODE, {14'd0, mode});
        write_reg(CFG_THR_ENABLE, {15'd0, te});
        write_reg(CFG_AMP_THR, amp);
        write_reg(CFG_CHG_THR, chg);
        write_reg(CFG_EXCL_HW, {10'd0, hw});
    endtask

    // Wait for every flag, then let the block finish any work that emits nothing
    task automatic drain();
        do @(posedge clk);
        while (sample_q.size() != 0 || in_valid || flag_fifo.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic void push(int v, bit l);
        sample_t s;
        s.value = v[15:0];
        s.last = l;
        sample_q.push_back(s);
    endfunction

    // One phase of random sequences; the last one may stay open across a config change
    function automatic void random_phase(int total, bit close_last);
        int v, len, kind, step;
        int made;
        made = 0;
        while (made < total)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 75) : $urandom_range(1, 24);
            if (made + len > total)
                len = total - made;
            kind = $urandom_range(3);
            v = $signed(16'($urandom));
            for (int i = 0; i < len; i++)
            begin
                case (kind)
                    0: v = $signed(16'($urandom));
                    1, 2:
                    begin
                        step = ($urandom_range(4) == 0) ? 0 : $urandom_range(0, 600) - 300;
                        v += step;
                        if (v > 32767) v = 32767;
                        if (v < -32768) v = -32768;
                    end
                    default: v = $urandom_range(0, 16) - 8;
                endcase
                made++;
                push(v, (i == len - 1) && (close_last || made < total));
            end
        end
        if ($urandom_range(9) == 0)
            push($urandom, 1'b1);   // occasional lone sample
    endfunction

    initial
    begin
        m_mode = MODE_THREE;
        m_thr_en = 1'b0;
        m_amp = '0;
        m_chg = '0;
        m_hw = '0;
        foreach (win[i])
        begin
            win[i] = 0;
            pbits[i] = 1'b0;
        end
        seq_cnt = 0;
        emit_pos = 0;
        cls_pos = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle = 29;
        rx_idle = 75;

        // Directed: lone sample, one-sided ties, field extremes, a strict seven-point peak
        push(5, 1'b1);
        push(0, 0); push(3, 0); push(3, 0); push(1, 0);
        push(-32768, 0); push(32767, 0); push(32767, 0); push(0, 1'b1);
        push(-3, 0); push(-2, 0); push(-1, 0); push(5, 0); push(1, 0); push(0, 0);
        push(-1, 1'b1);
        drain();
        configure(MODE_SEVEN, 1'b0, 16'h0000, 16'h0000, 6'd0);
        push(-3, 0); push(-2, 0); push(-1, 0); push(5, 0); push(1, 0); push(0, 0);
        push(-1, 1'b1);
        push(-32768, 0); push(-100, 0); push(0, 0); push(32767, 0); push(-2, 0);
        push(-200, 0); push(-32768, 0); push(0, 1'b1);
        drain();

        for (int p = 1; p <= 8; p++)
        begin
            if (p == 4)
            begin
                tx_idle = 75;
                rx_idle = 29;
            end
            else if (p == 7)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case (p)
                1: configure(MODE_FIVE, 1'b1, 16'h8000, 16'd0, 6'd1);
                2: configure(MODE_SEVEN, 1'b0, 16'h7FFF, 16'hFFFF, 6'd32);
                3: configure(MODE_ALIAS, 1'b1, 16'h7FFF, 16'd0, 6'd0);
                4: configure(MODE_THREE, 1'b1, 16'h0000, 16'd4096, 6'd63);
                5: configure(MODE_FIVE, 1'b0, 16'($urandom), 16'($urandom_range(1, 8192)),
                             6'($urandom_range(0, 40)));
                6: configure(MODE_THREE, 1'b0, 16'h0000, 16'd1, 6'd5);
                7: configure(MODE_SEVEN, 1'b1, 16'hFF9C, 16'd2048, 6'd3);
                default: configure(2'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                                   6'($urandom));
            endcase
            if (p == 2)
                hold_req++;        // receiver backs up while samples keep coming
            tx_pause = (p == 5);
            random_phase(47, !(p == 3 || p == 6));
            if (p == 5)
            begin
                repeat (50) @(posedge clk);
                tx_pause = 1'b0;
            end
            drain();
        end

        $display("Covered %0d samples and %0d register writes, checked %0d flags (%0d peaks)",
                 n_samples, n_cfg, n_flags, n_peaks);
        $display("across all peak modes, threshold and change extremes and exclusion widths.");
        if (errors == 0 && flag_fifo.size() == 0)
            $display("window_peak_detector verification clean");
        else
            $display("window_peak_detector verification failed");
        $finish;
    end

endmodule
